// ===== rtl/mlfqs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfqs_pkg
// Shared types, constants and arithmetic helpers of the MLFQS priority engine.
// ----------------------------------------------------------------------------
package mlfqs_pkg;

    // Table geometry and fixed-point format
    localparam int MAX_THREADS  = 64;
    localparam int SLOT_W       = $clog2(MAX_THREADS);
    localparam int FRAC_BITS    = 14;
    localparam int SLICE_TICKS  = 4;
    localparam int SLICE_W      = 3;
    localparam int TOP_PRIORITY = 63;
    localparam int PRI_W        = 6;
    localparam int RC_W         = 32;
    localparam int NICE_W       = 6;
    localparam int TPS_W        = 10;
    localparam int TPS_RESET    = 100;
    localparam int READY_W      = 7;
    localparam int PRI_PERIOD_W = 2;      // priorities refresh every 4th tick
    localparam int ENTRY_W      = RC_W + NICE_W + PRI_W;

    // Load average: never exceeds (max ready) * one, so 22 bits unsigned
    localparam int LA_W         = 22;
    localparam int TWICE_W      = LA_W + 1;
    localparam int DIVD_W       = TWICE_W + FRAC_BITS;
    localparam int DIVS_W       = TWICE_W;
    localparam int COEF_W       = FRAC_BITS;
    localparam int FP_ONE       = 1 << FRAC_BITS;
    localparam int LA_DECAY_NUM = 59;
    localparam int LA_DEN       = 60;
    localparam int SCALE_X100   = 100;
    localparam int PROD_W       = RC_W + COEF_W + 1;
    localparam int RC100_P_W    = RC_W + 8;
    localparam int LA100_P_W    = LA_W + 7;

    // Result fields
    localparam int RC100_W      = 25;
    localparam int LA100_W      = 13;
    localparam int LA100_MAX    = (1 << LA100_W) - 1;

    // Stream packing
    localparam int S_TDATA_W    = 32;
    localparam int S_TUSER_W    = 3;
    localparam int M_TDATA_W    = 56;
    localparam int S_SLOT_LSB   = 0;
    localparam int S_IDLE_BIT   = S_SLOT_LSB + SLOT_W;
    localparam int S_READY_LSB  = S_IDLE_BIT + 1;
    localparam int S_NICE_LSB   = S_READY_LSB + READY_W;
    localparam int S_INIT_LSB   = S_NICE_LSB + NICE_W;
    localparam int M_USED_W     = SLOT_W + PRI_W + RC100_W + LA100_W + 1;

    localparam logic signed [NICE_W-1:0] NICE_HI = 6'sd20;
    localparam logic signed [NICE_W-1:0] NICE_LO = -6'sd20;

    // Configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = TPS_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TPS    = 1'd1;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SET_NICE = 3'd1,
        CMD_CREATE   = 3'd2,
        CMD_EXIT     = 3'd3,
        CMD_SWITCH   = 3'd4,
        CMD_READ     = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        DIV_DECAY,
        DIV_ARRIVE,
        DIV_COEF
    } t_div_sel;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_A,
        ST_DIV_A_W,
        ST_DIV_B,
        ST_DIV_B_W,
        ST_DIV_C,
        ST_DIV_C_W,
        ST_RD,
        ST_LD,
        ST_MUL,
        ST_AGE,
        ST_PRI,
        ST_WR,
        ST_CREATE,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_MUL,
        ST_OUT_FIN
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        t_div_sel div_sel;
        logic     idx_zero;
        logic     idx_slot;
        logic     idx_inc;
        logic     mem_rd;
        logic     rd_slot;
        logic     ld;
        logic     mul;
        logic     age;
        logic     pri;
        logic     wr;
        logic     create;
        logic     out_ld;
        logic     out_mul;
        logic     out_load;
    } t_dp_ctrl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       slot_valid;
        logic       sec;
        logic       walk;
        logic       inc;
        logic       div_done;
        logic       idx_last;
    } t_dp_status;

    // Saturate a 34-bit sum to the signed 32-bit recent_cpu range
    function automatic logic signed [RC_W-1:0] sat_rc(input logic signed [RC_W+1:0] v);
        logic [2:0] top;
        top = v[RC_W+1:RC_W-1];
        if (top == 3'b000 || top == 3'b111) begin
            return v[RC_W-1:0];
        end else if (v[RC_W+1]) begin
            return {1'b1, {(RC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(RC_W-1){1'b1}}};
        end
    endfunction

    localparam int PW = RC_W + 4;

    // TOP - trunc(rc/4) - 2*nice, floored and clamped to 0..TOP
    function automatic logic [PRI_W-1:0] calc_priority(input logic signed [RC_W-1:0]   rc,
                                                       input logic signed [NICE_W-1:0] nice);
        logic signed [RC_W:0]   q4;
        logic signed [PW-1:0]   top_fp;
        logic signed [PW-1:0]   q4_ext;
        logic signed [PW-1:0]   nice_sh;
        logic signed [PW-1:0]   p;
        logic signed [PW-1:0]   ip;
        q4 = {rc[RC_W-1], rc};
        if (rc[RC_W-1]) begin
            q4 = q4 + 3;
        end
        q4      = q4 >>> 2;
        top_fp  = PW'(TOP_PRIORITY) << FRAC_BITS;
        q4_ext  = {{(PW-RC_W-1){q4[RC_W]}}, q4};
        nice_sh = {{(PW-NICE_W){nice[NICE_W-1]}}, nice};
        nice_sh = nice_sh <<< (FRAC_BITS + 1);
        p       = top_fp - q4_ext - nice_sh;
        ip      = p >>> FRAC_BITS;
        if (ip[PW-1]) begin
            return '0;
        end else if (ip > PW'(TOP_PRIORITY)) begin
            return PRI_W'(TOP_PRIORITY);
        end else begin
            return ip[PRI_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mlfqs_priority_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfqs_priority_engine
// Multilevel feedback queue scheduler core: per-slot recent_cpu, nice and
// priority, plus load average and slice/second tick accounting.
// ----------------------------------------------------------------------------
// Each command item yields exactly one result item for its slot. A plain
// command (read, create, exit, switch, set nice, an ordinary tick) needs no
// table walk. A tick that lands on a priority refresh (every 4th tick count)
// walks all 64 slots through the simple dual-port slot table, each slot in
// turn through read, load, multiply, age, priority and write. A tick at a
// second boundary first runs three serial divisions (decay, arrivals, aging
// coefficient) on the one shared divider, then the walk. One item is in work
// at a time; the finished result sits in an output register, so the next
// item is accepted while it waits. The table needs no clearing pass after
// reset: a per-slot written bit makes never-created slots read as zero.
// Configuration writes are taken any cycle.
// ----------------------------------------------------------------------------
module mlfqs_priority_engine (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration: index 0 mlfqs_enable, index 1 ticks_per_second
    input  wire logic                               i_cfg_we,
    input  wire logic [mlfqs_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [mlfqs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Command items
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [5:0] thread_slot, [6] running_idle, [13:7] ready_count,
    // [19:14] nice_value, [25:20] initial_priority, [31:26] zero
    input  wire logic [mlfqs_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // [2:0] command
    input  wire logic [mlfqs_pkg::S_TUSER_W-1:0]    i_s_tuser,
    // Result items
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [5:0] slot_out, [11:6] priority_out, [36:12] recent_cpu_x100,
    // [49:37] load_avg_x100, [50] yield_request, [55:51] zero
    output logic      [mlfqs_pkg::M_TDATA_W-1:0]    o_m_tdata
);
    import mlfqs_pkg::*;

    t_dp_ctrl   ctrl;
    t_dp_status status;

    // Sequencer: owns the handshakes and steps the datapath
    mlfqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    // Datapath: tables, counters, divider and fixed-point math
    mlfqs_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_ctrl     (ctrl),
        .o_status   (status),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/mlfqs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfqs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlfqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/mlfqs_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfqs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mlfqs_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic [mlfqs_pkg::DIVD_W-1:0]        i_dividend,
    input  wire logic [mlfqs_pkg::DIVS_W-1:0]        i_divisor,
    output logic                                     o_done,
    output logic      [mlfqs_pkg::DIVD_W-1:0]        o_quotient
);
    import mlfqs_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIVS_W:0]   trial;
    logic              fits;
    logic [DIVS_W:0]   diff;

    assign trial = {r_rem, r_quo[DIVD_W-1]};
    assign fits  = trial >= {1'b0, r_dsr};
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== rtl/mlfqs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfqs_datapath
// Slot table, counters, load average, divider and fixed-point arithmetic.
// ----------------------------------------------------------------------------
module mlfqs_datapath (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mlfqs_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [mlfqs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [mlfqs_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  wire logic [mlfqs_pkg::S_TUSER_W-1:0]    i_s_tuser,
    input  wire mlfqs_pkg::t_dp_ctrl                i_ctrl,
    output mlfqs_pkg::t_dp_status                   o_status,
    output logic      [mlfqs_pkg::M_TDATA_W-1:0]    o_m_tdata
);
    import mlfqs_pkg::*;

    // Input fields
    logic [2:0]               in_cmd;
    logic [SLOT_W-1:0]        in_slot;
    logic                     in_idle;
    logic [READY_W-1:0]       in_ready;
    logic signed [NICE_W-1:0] in_nice;
    logic signed [NICE_W-1:0] nice_clamped;
    logic [PRI_W-1:0]         in_init;

    assign in_cmd   = i_s_tuser[2:0];
    assign in_slot  = i_s_tdata[S_SLOT_LSB +: SLOT_W];
    assign in_idle  = i_s_tdata[S_IDLE_BIT];
    assign in_ready = i_s_tdata[S_READY_LSB +: READY_W];
    assign in_nice  = $signed(i_s_tdata[S_NICE_LSB +: NICE_W]);
    assign in_init  = i_s_tdata[S_INIT_LSB +: PRI_W];

    always_comb begin
        if (in_nice > NICE_HI) begin
            nice_clamped = NICE_HI;
        end else if (in_nice < NICE_LO) begin
            nice_clamped = NICE_LO;
        end else begin
            nice_clamped = in_nice;
        end
    end

    // Global state
    logic                     r_enable;
    logic [TPS_W-1:0]         r_tps;
    logic [SLICE_W-1:0]       r_slice;
    logic [TPS_W-1:0]         r_sec_cnt;
    logic [LA_W-1:0]          r_load;
    logic [LA_W-1:0]          r_tmp;
    logic [COEF_W-1:0]        r_coef;
    logic [MAX_THREADS-1:0]   r_valid;
    logic [MAX_THREADS-1:0]   r_written;   // entry holds data, else reads as zero
    t_div_sel                 r_div_sel;

    // Captured item
    logic [2:0]               r_cmd;
    logic [SLOT_W-1:0]        r_slot;
    logic                     r_idle;
    logic [READY_W-1:0]       r_ready;
    logic signed [NICE_W-1:0] r_nice;
    logic [PRI_W-1:0]         r_init;
    logic                     r_yield;
    logic                     r_sec;
    logic                     r_walk;
    logic                     r_inc;
    logic                     r_pri_on;

    // Work registers
    logic [SLOT_W-1:0]        r_idx;
    logic signed [RC_W-1:0]   r_rc;
    logic signed [NICE_W-1:0] r_wnice;
    logic [PRI_W-1:0]         r_wpri;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RC100_P_W-1:0] r_rc100_p;
    logic [LA100_P_W-1:0]     r_la100_p;

    // Output register payload
    logic [SLOT_W-1:0]        r_o_slot;
    logic [PRI_W-1:0]         r_o_pri;
    logic [RC100_W-1:0]       r_o_rc100;
    logic [LA100_W-1:0]       r_o_la100;
    logic                     r_o_yield;

    // Tick counters
    logic [SLICE_W-1:0]       slice_nx;
    logic [TPS_W:0]           sec_sum;
    logic                     sec_bnd;
    logic [TPS_W-1:0]         sec_nx;

    assign slice_nx = (r_slice < SLICE_W'(SLICE_TICKS)) ? r_slice + 1'b1 : r_slice;
    assign sec_sum  = {1'b0, r_sec_cnt} + 1'b1;
    assign sec_bnd  = sec_sum >= {1'b0, r_tps};
    assign sec_nx   = sec_bnd ? '0 : sec_sum[TPS_W-1:0];

    // Divider
    logic [DIVD_W-1:0]  div_dvd;
    logic [DIVS_W-1:0]  div_dsr;
    logic               div_done;
    logic [DIVD_W-1:0]  div_quo;
    logic [READY_W:0]   ready_tot;
    logic [TWICE_W-1:0] twice;

    assign ready_tot = {1'b0, r_ready} + {{READY_W{1'b0}}, !r_idle};
    assign twice     = {r_load, 1'b0};

    always_comb begin
        case (i_ctrl.div_sel)
            DIV_ARRIVE: begin
                div_dvd = DIVD_W'(ready_tot) << FRAC_BITS;
                div_dsr = DIVS_W'(LA_DEN);
            end
            DIV_COEF: begin
                div_dvd = DIVD_W'(twice) << FRAC_BITS;
                div_dsr = twice + DIVS_W'(FP_ONE);
            end
            default: begin
                div_dvd = DIVD_W'(r_load) * DIVD_W'(LA_DECAY_NUM);
                div_dsr = DIVS_W'(LA_DEN);
            end
        endcase
    end

    mlfqs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Slot table
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [SLOT_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    assign ram_we    = i_ctrl.create || (i_ctrl.wr && r_valid[r_idx]);
    assign ram_waddr = i_ctrl.create ? r_slot : r_idx;
    assign ram_wdata = i_ctrl.create ? {{(RC_W + NICE_W){1'b0}}, r_init}
                                     : {r_rc, r_wnice, r_wpri};
    assign ram_raddr = i_ctrl.rd_slot ? r_slot : r_idx;

    mlfqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_THREADS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctrl.mem_rd),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Entry unpack, never-written entries read as zero
    logic [SLOT_W-1:0]        ent_idx;
    logic [ENTRY_W-1:0]       ent;
    logic signed [RC_W-1:0]   ent_rc;
    logic signed [NICE_W-1:0] ent_nice;
    logic [PRI_W-1:0]         ent_pri;
    logic signed [RC_W+1:0]   inc_sum;
    logic signed [RC_W-1:0]   ld_rc;

    assign ent_idx  = i_ctrl.out_ld ? r_slot : r_idx;
    assign ent      = r_written[ent_idx] ? ram_rdata : '0;
    assign ent_rc   = $signed(ent[ENTRY_W-1 -: RC_W]);
    assign ent_nice = $signed(ent[PRI_W +: NICE_W]);
    assign ent_pri  = ent[PRI_W-1:0];
    assign inc_sum  = $signed({{2{ent_rc[RC_W-1]}}, ent_rc}) + $signed((RC_W+2)'(FP_ONE));
    assign ld_rc    = (r_inc && r_idx == r_slot) ? sat_rc(inc_sum) : ent_rc;

    // Aging: floor(coef * rc) + nice
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [RC_W+1:0]   nice_fp;
    logic signed [RC_W+1:0]   age_sum;

    assign prod_sh = r_prod >>> FRAC_BITS;
    assign nice_fp = $signed({{(RC_W+2-NICE_W){r_wnice[NICE_W-1]}}, r_wnice}) <<< FRAC_BITS;
    assign age_sum = $signed(prod_sh[RC_W+1:0]) + nice_fp;

    // x100 rounding, halves away from zero
    logic signed [RC100_P_W-1:0] rc_rnd;
    logic [LA100_P_W:0]          la_rnd;
    logic [LA100_P_W:0]          la_q;

    assign rc_rnd = (r_rc100_p + (r_rc100_p[RC100_P_W-1] ? RC100_P_W'(FP_ONE / 2 - 1)
                                                        : RC100_P_W'(FP_ONE / 2)))
                    >>> FRAC_BITS;
    assign la_rnd = {1'b0, r_la100_p} + (LA100_P_W + 1)'(FP_ONE / 2);
    assign la_q   = la_rnd >> FRAC_BITS;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_tps     <= TPS_W'(TPS_RESET);
            r_slice   <= '0;
            r_sec_cnt <= '0;
            r_load    <= '0;
            r_valid   <= '0;
            r_written <= '0;
            r_div_sel <= DIV_DECAY;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_TPS:    r_tps    <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_ctrl.capture) begin
                unique case (in_cmd)
                    CMD_TICK: begin
                        r_slice   <= slice_nx;
                        r_sec_cnt <= sec_nx;
                    end
                    CMD_CREATE: begin
                        r_valid[in_slot]   <= 1'b1;
                        r_written[in_slot] <= 1'b1;
                    end
                    CMD_EXIT:   r_valid[in_slot] <= 1'b0;
                    CMD_SWITCH: r_slice <= '0;
                    default:    ;
                endcase
            end
            if (i_ctrl.div_start) begin
                r_div_sel <= i_ctrl.div_sel;
            end
            if (div_done) begin
                case (r_div_sel)
                    DIV_ARRIVE: r_load <= r_tmp + div_quo[LA_W-1:0];
                    DIV_COEF:   r_coef <= div_quo[COEF_W-1:0];
                    default:    r_tmp  <= div_quo[LA_W-1:0];
                endcase
            end
        end
    end

    // Item capture and per-slot work
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd    <= in_cmd;
            r_slot   <= in_slot;
            r_idle   <= in_idle;
            r_ready  <= in_ready;
            r_nice   <= nice_clamped;
            r_init   <= in_init;
            r_yield  <= 1'b0;
            r_sec    <= 1'b0;
            r_walk   <= 1'b0;
            r_inc    <= 1'b0;
            r_pri_on <= 1'b0;
            if (in_cmd == CMD_TICK) begin
                r_yield  <= slice_nx >= SLICE_W'(SLICE_TICKS);
                r_sec    <= r_enable && sec_bnd;
                r_walk   <= r_enable && (sec_nx[PRI_PERIOD_W-1:0] == '0);
                r_pri_on <= r_enable && (sec_nx[PRI_PERIOD_W-1:0] == '0);
                r_inc    <= r_enable && !in_idle && r_valid[in_slot];
            end else if (in_cmd == CMD_SET_NICE) begin
                r_yield  <= 1'b1;
                r_pri_on <= r_enable;
            end
        end

        if (i_ctrl.idx_zero) begin
            r_idx <= '0;
        end else if (i_ctrl.idx_slot) begin
            r_idx <= r_slot;
        end else if (i_ctrl.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end

        if (i_ctrl.ld) begin
            r_rc    <= ld_rc;
            r_wnice <= (r_cmd == CMD_SET_NICE) ? r_nice : ent_nice;
            r_wpri  <= ent_pri;
        end else if (i_ctrl.out_ld) begin
            r_rc    <= ent_rc;
            r_wpri  <= ent_pri;
        end else if (i_ctrl.age && r_sec) begin
            r_rc    <= sat_rc(age_sum);
        end else if (i_ctrl.pri && r_pri_on) begin
            r_wpri  <= calc_priority(r_rc, r_wnice);
        end

        if (i_ctrl.mul) begin
            r_prod <= $signed({1'b0, r_coef}) * r_rc;
        end

        if (i_ctrl.out_mul) begin
            r_rc100_p <= r_rc * $signed(8'd100);
            r_la100_p <= r_load * 7'(SCALE_X100);
        end

        if (i_ctrl.out_load) begin
            r_o_slot  <= r_slot;
            r_o_pri   <= r_wpri;
            r_o_rc100 <= rc_rnd[RC100_W-1:0];   // |rc| * 100 / one stays below 2^24
            r_o_la100 <= (la_q > (LA100_P_W + 1)'(LA100_MAX)) ? LA100_W'(LA100_MAX)
                                                                : la_q[LA100_W-1:0];
            r_o_yield <= r_yield;
        end
    end

    assign o_status.cmd        = r_cmd;
    assign o_status.slot_valid = r_valid[r_slot];
    assign o_status.sec        = r_sec;
    assign o_status.walk       = r_walk;
    assign o_status.inc        = r_inc;
    assign o_status.div_done   = div_done;
    assign o_status.idx_last   = (r_idx == SLOT_W'(MAX_THREADS - 1));

    assign o_m_tdata = {{(M_TDATA_W - M_USED_W){1'b0}},
                        r_o_yield, r_o_la100, r_o_rc100, r_o_pri, r_o_slot};

endmodule
`default_nettype wire

// ===== rtl/mlfqs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlfqs_ctrl
// Command sequencer: divisions, table walk, result read-out, output register.
// ----------------------------------------------------------------------------
module mlfqs_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    input  wire mlfqs_pkg::t_dp_status  i_status,
    output mlfqs_pkg::t_dp_ctrl         o_ctrl
);
    import mlfqs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_s_tvalid) n_state = ST_DECODE;
            ST_DECODE: begin
                unique case (i_status.cmd)
                    CMD_TICK: begin
                        if (i_status.sec) begin
                            n_state = ST_DIV_A;
                        end else if (i_status.walk || i_status.inc) begin
                            n_state = ST_RD;
                        end else begin
                            n_state = ST_OUT_RD;
                        end
                    end
                    CMD_SET_NICE: n_state = i_status.slot_valid ? ST_RD : ST_OUT_RD;
                    CMD_CREATE:   n_state = ST_CREATE;
                    default:      n_state = ST_OUT_RD;
                endcase
            end
            ST_DIV_A:   n_state = ST_DIV_A_W;
            ST_DIV_A_W: if (i_status.div_done) n_state = ST_DIV_B;
            ST_DIV_B:   n_state = ST_DIV_B_W;
            ST_DIV_B_W: if (i_status.div_done) n_state = ST_DIV_C;
            ST_DIV_C:   n_state = ST_DIV_C_W;
            ST_DIV_C_W: if (i_status.div_done) n_state = ST_RD;
            ST_RD:      n_state = ST_LD;
            ST_LD:      n_state = ST_MUL;
            ST_MUL:     n_state = ST_AGE;
            ST_AGE:     n_state = ST_PRI;
            ST_PRI:     n_state = ST_WR;
            ST_WR:      n_state = (i_status.walk && !i_status.idx_last) ? ST_RD : ST_OUT_RD;
            ST_CREATE:  n_state = ST_OUT_RD;
            ST_OUT_RD:  n_state = ST_OUT_LD;
            ST_OUT_LD:  n_state = ST_OUT_MUL;
            ST_OUT_MUL: n_state = ST_OUT_FIN;
            ST_OUT_FIN: if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ctrl         = '0;
        o_ctrl.div_sel = DIV_DECAY;
        o_s_tready     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready     = 1'b1;
                o_ctrl.capture = i_s_tvalid;
            end
            ST_DECODE: begin
                o_ctrl.idx_zero = i_status.walk;
                o_ctrl.idx_slot = !i_status.walk;
            end
            ST_DIV_A: begin
                o_ctrl.div_start = 1'b1;
                o_ctrl.div_sel   = DIV_DECAY;
            end
            ST_DIV_B: begin
                o_ctrl.div_start = 1'b1;
                o_ctrl.div_sel   = DIV_ARRIVE;
            end
            ST_DIV_C: begin
                o_ctrl.div_start = 1'b1;
                o_ctrl.div_sel   = DIV_COEF;
            end
            ST_RD:      o_ctrl.mem_rd = 1'b1;
            ST_LD:      o_ctrl.ld     = 1'b1;
            ST_MUL:     o_ctrl.mul    = 1'b1;
            ST_AGE:     o_ctrl.age    = 1'b1;
            ST_PRI:     o_ctrl.pri    = 1'b1;
            ST_WR: begin
                o_ctrl.wr      = 1'b1;
                o_ctrl.idx_inc = i_status.walk && !i_status.idx_last;
            end
            ST_CREATE:  o_ctrl.create = 1'b1;
            ST_OUT_RD: begin
                o_ctrl.mem_rd  = 1'b1;
                o_ctrl.rd_slot = 1'b1;
            end
            ST_OUT_LD:  o_ctrl.out_ld   = 1'b1;
            ST_OUT_MUL: o_ctrl.out_mul  = 1'b1;
            ST_OUT_FIN: o_ctrl.out_load = out_free;
            default:    ;
        endcase
    end

    // Output register: holds one finished result until taken
    always_comb begin
        if (o_ctrl.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mlfqs_priority_engine: a directed command table,
// then random command mixes under several enable/tick-rate settings, each
// result compared field by field against a cycle-free priority model or a typed row.
// ----------------------------------------------------------------------------
module tb;
    import mlfqs_pkg::*;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam longint     ONE       = 64'sd1 << FRAC_BITS;
    localparam int         STALL_MAX = 20000;   // cycles with no handshake

    typedef struct {
        logic [2:0]        cmd;
        logic [5:0]        slot;
        logic              idle;
        logic [6:0]        ready;
        logic signed [5:0] nice;
        logic [5:0]        init;
        bit                typed;      // expected result typed in below
        logic [5:0]        pri;
        int                rc100;
        int                la100;
        logic              yld;
    } t_row;

    typedef struct {
        logic [5:0]         slot;
        logic [5:0]         pri;
        logic signed [24:0] rc100;
        logic [12:0]        la100;
        logic               yld;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = '0;
    logic [9:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    always #5 i_clk = ~i_clk;

    mlfqs_priority_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // Scheduler model state
    longint  rcpu [64];
    int      nice_t [64];
    int      pri_t [64];
    bit      valid_t [64];
    longint  load_avg;
    int      slice_cnt;
    int      sec_cnt;
    bit      en_cfg;
    int      tps_cfg;

    t_res    expected_q [$];
    int      errors = 0;
    int      tx_gap_pct = 22;
    int      rx_gap_pct = 22;
    int      quiet = 0;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint x100(longint v);
        longint p;
        p = v * 100;
        if (p >= 0) return (p + ONE / 2) / ONE;
        return -((-p + ONE / 2) / ONE);
    endfunction

    function automatic void refresh_pri(int i);
        longint p;
        longint ip;
        p  = 63 * ONE - rcpu[i] / 4 - 2 * longint'(nice_t[i]) * ONE;
        ip = p >>> FRAC_BITS;
        if (ip < 0) ip = 0;
        if (ip > TOP_PRIORITY) ip = TOP_PRIORITY;
        pri_t[i] = int'(ip);
    endfunction

    function automatic void age_second(longint ready);
        longint twice;
        longint coef;
        load_avg = (load_avg * 59) / 60 + (ready * ONE) / 60;
        twice    = 2 * load_avg;
        coef     = (twice * ONE) / (twice + ONE);
        for (int i = 0; i < 64; i++) begin
            if (valid_t[i]) begin
                rcpu[i] = sat32(((coef * rcpu[i]) >>> FRAC_BITS)
                                + longint'(nice_t[i]) * ONE);
                refresh_pri(i);
            end
        end
    endfunction

    function automatic t_res schedule_step(logic [2:0] cmd, logic [5:0] slot, logic idle,
                                           logic [6:0] ready, logic signed [5:0] nice_in,
                                           logic [5:0] init);
        t_res   r;
        int     nv;
        int     s;
        longint rc;
        longint la;
        r.yld = 1'b0;
        s  = slot;
        nv = nice_in;
        if (nv > 20) nv = 20;
        if (nv < -20) nv = -20;
        case (cmd)
            CMD_TICK: begin
                if (en_cfg && !idle && valid_t[s]) rcpu[s] = sat32(rcpu[s] + ONE);
                if (slice_cnt < SLICE_TICKS) slice_cnt++;
                r.yld = (slice_cnt >= SLICE_TICKS);
                sec_cnt++;
                if (sec_cnt >= tps_cfg) begin
                    sec_cnt = 0;
                    if (en_cfg) age_second(longint'(ready) + (idle ? 0 : 1));
                end
                sec_cnt &= 'h3ff;
                if (en_cfg && (sec_cnt % 4) == 0)
                    for (int i = 0; i < 64; i++) if (valid_t[i]) refresh_pri(i);
            end
            CMD_SET_NICE: begin
                if (valid_t[s]) begin
                    nice_t[s] = nv;
                    if (en_cfg) refresh_pri(s);
                end
                r.yld = 1'b1;
            end
            CMD_CREATE: begin
                valid_t[s] = 1'b1;
                rcpu[s]    = 0;
                nice_t[s]  = 0;
                pri_t[s]   = init;
            end
            CMD_EXIT:   valid_t[s] = 1'b0;
            CMD_SWITCH: slice_cnt = 0;
            default: ;
        endcase
        rc = x100(rcpu[s]);
        if (rc > 16777215) rc = 16777215;
        if (rc < -16777216) rc = -16777216;
        la = x100(load_avg);
        if (la < 0) la = 0;
        if (la > 8191) la = 8191;
        r.slot  = slot;
        r.pri   = pri_t[s][5:0];
        r.rc100 = rc[24:0];
        r.la100 = la[12:0];
        return r;
    endfunction

    // Drive one command item and record its expected result on acceptance
    task automatic send_cmd(logic [2:0] cmd, logic [5:0] slot, logic idle, logic [6:0] ready,
                            logic signed [5:0] nice_in, logic [5:0] init,
                            bit typed, t_res typed_res);
        t_res r;
        while ($urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, init, nice_in, ready, idle, slot};
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!s_tready);
        r = schedule_step(cmd, slot, idle, ready, nice_in, init);
        expected_q.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [9:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_ENABLE) en_cfg = val[0];
        else tps_cfg = val;
    endtask

    // Random mix: mostly commands on a small pool of live threads
    task automatic random_phase(int n, bit pause_mid);
        t_res       none;
        logic [2:0] cmd;
        logic [5:0] slot;
        int         w;
        none = '{default: '0};
        for (int i = 0; i < 4; i++)
            send_cmd(CMD_CREATE, 6'(i), 1'b0, 7'd0, 6'sd0, 6'($urandom_range(63)), 0, none);
        for (int k = 0; k < n; k++) begin
            w = $urandom_range(99);
            if (w < 55) cmd = CMD_TICK;
            else if (w < 65) cmd = CMD_SET_NICE;
            else if (w < 73) cmd = CMD_CREATE;
            else if (w < 78) cmd = CMD_EXIT;
            else if (w < 89) cmd = CMD_SWITCH;
            else cmd = CMD_READ;
            slot = ($urandom_range(99) < 80) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
            send_cmd(cmd, slot, ($urandom_range(99) < 20), 7'($urandom_range(64)),
                     6'(int'($urandom_range(40)) - 20), 6'($urandom_range(63)), 0, none);
            if (pause_mid && k == n / 2) drain();
        end
        drain();
    endtask

    // Directed table; typed rows carry the result that is plain from the rules
    t_row rows [] = '{
        '{CMD_READ,     6'd0,  1'b0, 7'd0,  6'sd0,   6'd0,  1, 6'd0,  0, 0, 1'b0},
        '{CMD_CREATE,   6'd63, 1'b0, 7'd0,  6'sd0,   6'd63, 1, 6'd63, 0, 0, 1'b0},
        '{CMD_CREATE,   6'd0,  1'b0, 7'd0,  6'sd0,   6'd0,  1, 6'd0,  0, 0, 1'b0},
        // nice on a slot never created: nothing stored, yield anyway
        '{CMD_SET_NICE, 6'd5,  1'b0, 7'd0,  -6'sd20, 6'd0,  1, 6'd0,  0, 0, 1'b1},
        '{CMD_SET_NICE, 6'd63, 1'b0, 7'd0,  6'sd20,  6'd0,  1, 6'd23, 0, 0, 1'b1},
        '{CMD_SET_NICE, 6'd0,  1'b0, 7'd0,  -6'sd20, 6'd0,  1, 6'd63, 0, 0, 1'b1},
        '{CMD_TICK,     6'd63, 1'b0, 7'd64, 6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_TICK,     6'd63, 1'b1, 7'd0,  6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_TICK,     6'd0,  1'b0, 7'd64, 6'sd0,   6'd63, 0, 6'd0,  0, 0, 1'b0},
        '{CMD_TICK,     6'd0,  1'b0, 7'd63, 6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_TICK,     6'd0,  1'b0, 7'd1,  6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_SWITCH,   6'd0,  1'b0, 7'd0,  6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_TICK,     6'd63, 1'b0, 7'd5,  6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_EXIT,     6'd63, 1'b0, 7'd0,  6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        // exited slot still shows its stale entry
        '{CMD_READ,     6'd63, 1'b0, 7'd0,  6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_TICK,     6'd63, 1'b0, 7'd0,  6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_SET_NICE, 6'd63, 1'b0, 7'd0,  6'sd7,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_RSVD6,    6'd1,  1'b0, 7'd0,  6'sd0,   6'd0,  0, 6'd0,  0, 0, 1'b0},
        '{CMD_RSVD7,    6'd2,  1'b1, 7'd64, -6'sd1,  6'd42, 0, 6'd0,  0, 0, 1'b0},
        '{CMD_CREATE,   6'd10, 1'b0, 7'd0,  6'sd0,   6'd21, 0, 6'd0,  0, 0, 1'b0},
        '{CMD_READ,     6'd10, 1'b0, 7'd0,  6'sd0,   6'd0,  1, 6'd21, 0, 0, 1'b0}
    };

    // Result side: random back-pressure, compare, watchdog
    always @(posedge i_clk) begin
        t_res e;
        m_tready <= ($urandom_range(99) >= rx_gap_pct);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > STALL_MAX) begin
            $display("%0t watchdog: no handshake for %0d cycles", $time, quiet);
            $display("tb: failure");
            $finish;
        end
        if (m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result: %h", $time, m_tdata);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[5:0] !== e.slot) begin
                    $display("%0t slot: expected %0d actual %0d", $time, e.slot, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[11:6] !== e.pri) begin
                    $display("%0t priority: expected %0d actual %0d", $time, e.pri,
                             m_tdata[11:6]);
                    errors++;
                end
                if (m_tdata[36:12] !== e.rc100) begin
                    $display("%0t recent_cpu_x100: expected %0d actual %0d", $time, e.rc100,
                             $signed(m_tdata[36:12]));
                    errors++;
                end
                if (m_tdata[49:37] !== e.la100) begin
                    $display("%0t load_avg_x100: expected %0d actual %0d", $time, e.la100,
                             m_tdata[49:37]);
                    errors++;
                end
                if (m_tdata[50] !== e.yld) begin
                    $display("%0t yield: expected %0d actual %0d", $time, e.yld, m_tdata[50]);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_res tr;
        for (int i = 0; i < 64; i++) begin
            rcpu[i] = 0; nice_t[i] = 0; pri_t[i] = 0; valid_t[i] = 0;
        end
        load_avg  = 0;
        slice_cnt = 0;
        sec_cnt   = 0;
        en_cfg    = 1'b1;
        tps_cfg   = TPS_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            tr = '{rows[i].slot, rows[i].pri, 25'(rows[i].rc100), 13'(rows[i].la100),
                   rows[i].yld};
            send_cmd(rows[i].cmd, rows[i].slot, rows[i].idle, rows[i].ready, rows[i].nice,
                     rows[i].init, rows[i].typed, tr);
        end
        drain();

        // Every tick a second boundary: load average climbs fast
        write_reg(CFG_TPS, 10'd1);
        random_phase(190, 1);
        write_reg(CFG_ENABLE, 1'b0);
        write_reg(CFG_TPS, 10'd1000);
        random_phase(190, 0);
        write_reg(CFG_ENABLE, 1'b1);
        write_reg(CFG_TPS, 10'd4);
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        random_phase(190, 0);
        tx_gap_pct = 22;
        rx_gap_pct = 22;
        write_reg(CFG_TPS, 10'd1000);
        random_phase(190, 0);
        write_reg(CFG_TPS, 10'd7);
        random_phase(190, 0);
        write_reg(CFG_TPS, 10'd2);
        random_phase(190, 0);

        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
